>>> rtl/dlfp_pkg.sv
// Shared types and constants for the decimal length frame parser.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package dlfp_pkg;

  localparam int LENGTH_WIDTH_DEF = 24;
  localparam int CFG_WIDTH        = 24;
  localparam logic [CFG_WIDTH-1:0] MAX_LENGTH_RESET = 24'd10485760;

  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_PAYLOAD     = 3'd0,
    ST_BAD_PREFIX  = 3'd1,
    ST_NO_DIGITS   = 3'd2,
    ST_ZERO_LENGTH = 3'd3,
    ST_TOO_LARGE   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_PREFIX1 = 4'b0001,
    PH_PREFIX2 = 4'b0010,
    PH_DIGITS  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  // One result word as produced by the parse step.
  typedef struct packed {
    logic       has_result;
    status_t    status;
    logic [7:0] payload_byte;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/dlfp_in_reg.sv
// Input register stage: captures one byte word per cycle unless held.
// Depends on dlfp_pkg (no items used beyond the common house import).
`default_nettype none

module dlfp_in_reg
  import dlfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       hold,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  output logic            s1_valid,
  output logic [7:0]      s1_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!hold) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      byte_r <= in_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

`default_nettype wire

>>> rtl/dlfp_parse.sv
// Frame parsing state and the one-byte step logic.
// Depends on dlfp_pkg for phase, status and result types.
`default_nettype none

module dlfp_parse
  import dlfp_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 advance,
  input  wire logic [7:0]           cur_byte,
  input  wire logic [CFG_WIDTH-1:0] max_length,
  output res_t                      res
);

  localparam int ACCW = LENGTH_WIDTH + 1;
  localparam int MULW = LENGTH_WIDTH + 5;
  localparam int CMPW = (ACCW > CFG_WIDTH) ? ACCW : CFG_WIDTH;
  localparam logic [MULW-1:0] CAP = MULW'(1) << LENGTH_WIDTH;

  phase_t                  phase_r,      phase_nxt;
  logic                    first_ok_r,   first_ok_nxt;
  logic [ACCW-1:0]         acc_r,        acc_nxt;
  logic                    digit_seen_r, digit_seen_nxt;
  logic [LENGTH_WIDTH-1:0] remain_r,     remain_nxt;

  logic                    is_digit;
  logic [MULW-1:0]         acc_ext;
  logic [MULW-1:0]         acc_mac;
  logic [ACCW-1:0]         acc_minus1;
  logic [LENGTH_WIDTH-1:0] remain_dec;

  // acc * 10 + digit as two shifts and adds
  always_comb begin
    is_digit   = (cur_byte >= CHAR_ZERO) && (cur_byte <= CHAR_NINE);
    acc_ext    = MULW'(acc_r);
    acc_mac    = (acc_ext << 3) + (acc_ext << 1) + MULW'(cur_byte - CHAR_ZERO);
    acc_minus1 = acc_r - ACCW'(1);
    remain_dec = (remain_r != '0) ? (remain_r - LENGTH_WIDTH'(1)) : '0;
  end

  always_comb begin
    phase_nxt      = phase_r;
    first_ok_nxt   = first_ok_r;
    acc_nxt        = acc_r;
    digit_seen_nxt = digit_seen_r;
    remain_nxt     = remain_r;
    res            = '{has_result: 1'b0, status: ST_PAYLOAD, payload_byte: 8'd0, last: 1'b0};

    case (phase_r)
      PH_PREFIX1: begin
        first_ok_nxt = (cur_byte == CHAR_M);
        phase_nxt    = PH_PREFIX2;
      end
      PH_PREFIX2: begin
        if (first_ok_r && (cur_byte == CHAR_L)) begin
          acc_nxt        = '0;
          digit_seen_nxt = 1'b0;
          phase_nxt      = PH_DIGITS;
        end else begin
          phase_nxt      = PH_PREFIX1;
          res.has_result = 1'b1;
          res.status     = ST_BAD_PREFIX;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          // saturate one above the largest representable length
          acc_nxt        = (acc_mac > CAP) ? CAP[ACCW-1:0] : acc_mac[ACCW-1:0];
          digit_seen_nxt = 1'b1;
        end else begin
          phase_nxt      = PH_PREFIX1;
          res.has_result = 1'b1;
          if (!digit_seen_r) begin
            res.status = ST_NO_DIGITS;
          end else if (acc_r == '0) begin
            res.status = ST_ZERO_LENGTH;
          end else if (CMPW'(acc_r) > CMPW'(max_length)) begin
            res.status = ST_TOO_LARGE;
          end else begin
            // terminating byte is the first payload byte
            remain_nxt       = acc_minus1[LENGTH_WIDTH-1:0];
            res.status       = ST_PAYLOAD;
            res.payload_byte = cur_byte;
            res.last         = (acc_minus1[LENGTH_WIDTH-1:0] == '0);
            if (acc_minus1[LENGTH_WIDTH-1:0] != '0) begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        remain_nxt       = remain_dec;
        res.has_result   = 1'b1;
        res.status       = ST_PAYLOAD;
        res.payload_byte = cur_byte;
        res.last         = (remain_dec == '0);
        if (remain_dec == '0) begin
          phase_nxt = PH_PREFIX1;
        end
      end
      default: begin
        phase_nxt = PH_PREFIX1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_PREFIX1;
      first_ok_r   <= 1'b0;
      acc_r        <= '0;
      digit_seen_r <= 1'b0;
      remain_r     <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      first_ok_r   <= first_ok_nxt;
      acc_r        <= acc_nxt;
      digit_seen_r <= digit_seen_nxt;
      remain_r     <= remain_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/decimal_length_frame_parser.sv
// Top level of the decimal length frame parser: input stage, parse step,
// result register and the max_length register. Depends on dlfp_pkg,
// dlfp_in_reg and dlfp_parse.
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid, in_stall, in_byte                        | in
//  out     | out_valid, out_stall, out_status, out_payload_byte,| out
//          | out_last_of_frame                                  |
//  cfg     | cfg_wr_en, cfg_wr_data (max_length)                | in
//
// One byte word per cycle sustained unless out_stall holds a full result
// register; a taken word is parsed from the input register into the result
// register. A good header and digits give no result word; a bad prefix does.
// Synchronous active-low reset returns the parser to waiting for 'M' and
// loads max_length with 10 MiB.
// out_stall holds the result register; the input stage then stalls only
// once it is also full, so no word is dropped or duplicated.
`default_nettype none

module decimal_length_frame_parser
  import dlfp_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                out_status,
  output logic [7:0]                out_payload_byte,
  output logic                      out_last_of_frame,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_WIDTH-1:0] cfg_wr_data
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 out_free;
  logic                 s1_adv;
  res_t                 res;

  logic [CFG_WIDTH-1:0] max_length_r;
  logic                 out_valid_r,  out_valid_nxt;
  logic [2:0]           out_status_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;

  // result register can take a word when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  dlfp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .hold     (in_stall),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  dlfp_parse #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (s1_adv),
    .cur_byte   (s1_byte),
    .max_length (max_length_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_length_r <= cfg_wr_data;
    end
  end

  assign out_valid_nxt = out_free ? (s1_valid && res.has_result) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_status_r <= res.status;
      out_byte_r   <= res.payload_byte;
      out_last_r   <= res.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_payload_byte  = out_byte_r;
  assign out_last_of_frame = out_last_r;

  // error words never carry a byte or the end-of-frame mark
  a_err_no_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_PAYLOAD) |-> !out_last_of_frame)
    else $error("error word marked last of frame");

  a_err_zero_byte : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_PAYLOAD) |-> (out_payload_byte == 8'd0))
    else $error("error word carries a nonzero byte");

  a_status_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_TOO_LARGE))
    else $error("status code out of range");

  a_no_loss : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && out_valid && out_stall |=> s1_valid && out_valid)
    else $error("word lost while result stalled");

endmodule

`default_nettype wire

>>> tb/decimal_length_frame_parser_tb.sv
// Self-checking testbench for decimal_length_frame_parser: directed frames, then random
// frame traffic over several max_length settings and idle patterns.
// Depends on dlfp_pkg and the decimal_length_frame_parser RTL.

module decimal_length_frame_parser_tb;
  import dlfp_pkg::*;

  localparam int LW = LENGTH_WIDTH_DEF;
  // Saturation point of the length accumulator, one above any legal max_length.
  localparam logic [LW:0] LEN_CAP = (LW+1)'(1) << LW;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Cycles to let pass after the last expected word before touching max_length.
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           out_status;
  logic [7:0]           out_payload_byte;
  logic                 out_last_of_frame;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wr_data = '0;

  // Parser state as the testbench tracks it.
  phase_t               mdl_phase;
  logic                 mdl_m_seen;
  logic [LW:0]          mdl_len;
  logic                 mdl_any_digit;
  logic [LW-1:0]        mdl_left;
  logic [CFG_WIDTH-1:0] mdl_max_len;

  frame_word_t expected_words[$];
  int unsigned bytes_sent = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 29;
  int unsigned receiver_idle_pct = 54;

  decimal_length_frame_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_payload_byte  (out_payload_byte),
    .out_last_of_frame (out_last_of_frame),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure, independent of anything the sender does.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Append one expected word at the tail of the queue.
  task automatic queue_word(input frame_word_t w);
    expected_words = {expected_words, w};
  endtask

  // Advance the tracked parser by one accepted byte; queue the word it yields, if any.
  task automatic predict_byte(input logic [7:0] b);
    logic [LW+4:0] next_len;
    frame_word_t   w;
    w = '{ST_PAYLOAD, 8'h00, 1'b0};
    case (mdl_phase)
      PH_PREFIX1: begin
        mdl_m_seen = (b == CHAR_M);
        mdl_phase  = PH_PREFIX2;
      end
      PH_PREFIX2: begin
        // prefix judged only once both bytes are in
        if (mdl_m_seen && b == CHAR_L) begin
          mdl_len       = '0;
          mdl_any_digit = 1'b0;
          mdl_phase     = PH_DIGITS;
        end else begin
          mdl_phase = PH_PREFIX1;
          w.status  = ST_BAD_PREFIX;
          queue_word(w);
        end
      end
      PH_DIGITS: begin
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          next_len      = (LW+5)'(mdl_len) * (LW+5)'(10) + (LW+5)'(b - CHAR_ZERO);
          mdl_len       = (next_len > LEN_CAP) ? LEN_CAP : next_len[LW:0];
          mdl_any_digit = 1'b1;
        end else begin
          // terminating byte: either an error or the first payload byte
          mdl_phase = PH_PREFIX1;
          if (!mdl_any_digit) begin
            w.status = ST_NO_DIGITS;
          end else if (mdl_len == 0) begin
            w.status = ST_ZERO_LENGTH;
          end else if (mdl_len > mdl_max_len) begin
            w.status = ST_TOO_LARGE;
          end else begin
            mdl_left = mdl_len[LW-1:0] - 1'b1;
            if (mdl_left != 0) mdl_phase = PH_PAYLOAD;
            w.data = b;
            w.last = (mdl_left == 0);
          end
          queue_word(w);
        end
      end
      default: begin
        if (mdl_left != 0) mdl_left = mdl_left - 1'b1;
        if (mdl_left == 0) mdl_phase = PH_PREFIX1;
        w.data = b;
        w.last = (mdl_left == 0);
        queue_word(w);
      end
    endcase
  endtask

  // Offer one byte word; valid stays high after acceptance so back-to-back words
  // need no second assignment in the same step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stop sending and wait until every expected word has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [CFG_WIDTH-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mdl_max_len = value;
  endtask

  function automatic logic [7:0] pick_non_digit();
    logic [7:0] b;
    do b = 8'($urandom); while (b >= CHAR_ZERO && b <= CHAR_NINE);
    return b;
  endfunction

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Result checker: every accepted word against the oldest expectation.
  always @(posedge clk) begin : check_words
    frame_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        error_count++;
        $display("%0t: word with none expected: expected nothing, %s %0d byte %0h last %0b",
                 $time, "actual status", out_status, out_payload_byte, out_last_of_frame);
      end else begin
        want = expected_words.pop_front();
        compare_field("status", 8'(want.status), 8'(out_status));
        compare_field("payload_byte", want.data, out_payload_byte);
        compare_field("last_of_frame", 8'(want.last), 8'(out_last_of_frame));
      end
    end
  end

  // Wrong first byte, wrong second byte, and both extremes of the byte range.
  task automatic test_bad_prefix();
    send_byte(CHAR_M);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CHAR_L);
  endtask

  // '/' sits just below '0'.
  task automatic test_no_digits();
    send_text("ML/");
  endtask

  // ':' sits just above '9'.
  task automatic test_zero_length();
    send_text("ML00:");
  endtask

  // The terminating byte is the whole payload.
  task automatic test_length_one();
    send_text("ML1");
    send_byte(8'hFF);
  endtask

  task automatic test_short_frame();
    send_text("ML2");
    send_byte(8'h00);
    send_byte(CHAR_M);
  endtask

  // Smallest limit: one above is rejected, exactly at the limit passes.
  task automatic test_max_length_limits();
    write_max_length(CFG_WIDTH'(1));
    send_text("ML2x");
    send_text("ML1y");
  endtask

  // One frame or one piece of line noise, always ending with the parser awaiting 'M'.
  task automatic send_random_frame();
    logic [7:0]  digit_chars[$];
    int unsigned kind;
    int unsigned len;
    int unsigned val;
    kind = $urandom_range(99);
    if (kind < 12) begin
      // noise or a broken prefix, then non-digits until the parser resyncs
      send_byte($urandom_range(1) ? CHAR_M : 8'($urandom));
      while (mdl_phase != PH_PREFIX1) send_byte(pick_non_digit());
    end else begin
      send_byte(CHAR_M);
      send_byte(CHAR_L);
      kind = $urandom_range(99);
      if (kind >= 5) begin
        if (kind < 16) begin
          // overlong string, saturates the accumulator
          digit_chars = {digit_chars, 8'(CHAR_ZERO + $urandom_range(1, 9))};
          repeat ($urandom_range(8, 11))
            digit_chars = {digit_chars, 8'(CHAR_ZERO + $urandom_range(0, 9))};
        end else begin
          if (kind < 19)
            len = 0;
          else if (kind < 27)
            len = (mdl_max_len <= 100 && $urandom_range(1)) ? mdl_max_len
                                                          : mdl_max_len + 1;
          else if (kind < 75)
            len = $urandom_range(1, 8);
          else if (kind < 95)
            len = $urandom_range(9, 40);
          else
            len = $urandom_range(41, 100);
          val = len;
          do begin
            digit_chars.push_front(8'(CHAR_ZERO + val % 10));
            val = val / 10;
          end while (val != 0);
          if ($urandom_range(99) < 15) digit_chars.push_front(CHAR_ZERO);
        end
      end
      foreach (digit_chars[i]) send_byte(digit_chars[i]);
      send_byte(pick_non_digit());
      while (mdl_phase == PH_PAYLOAD) send_byte(8'($urandom));
    end
  endtask

  task automatic test_random_frames(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  initial begin
    logic [CFG_WIDTH-1:0] phase_max[6];
    mdl_phase     = PH_PREFIX1;
    mdl_m_seen    = 1'b0;
    mdl_len       = '0;
    mdl_any_digit = 1'b0;
    mdl_left      = '0;
    mdl_max_len   = MAX_LENGTH_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs against the reset value of max_length first
    test_bad_prefix();
    test_no_digits();
    test_zero_length();
    test_length_one();
    test_short_frame();
    test_max_length_limits();

    // two phases per idle pattern: sender-light, receiver-light, then no idling
    phase_max[0] = MAX_LENGTH_RESET;
    phase_max[1] = {CFG_WIDTH{1'b1}};
    phase_max[2] = CFG_WIDTH'(1);
    phase_max[3] = CFG_WIDTH'($urandom_range(2, 40));
    phase_max[4] = CFG_WIDTH'($urandom_range(41, 24'hFFFFFE));
    phase_max[5] = CFG_WIDTH'(5);
    for (int p = 0; p < 6; p++) begin
      write_max_length(phase_max[p]);
      case (p / 2)
        0: begin
          sender_idle_pct   = 29;
          receiver_idle_pct = 54;
        end
        1: begin
          sender_idle_pct   = 54;
          receiver_idle_pct = 29;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      test_random_frames(235);
    end

    drain_results();
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
